>>> rtl/tsa_pkg.sv
`timescale 1ns / 1ps

package tsa_pkg;

    // Span format: value = high * 2**SCALE_BITS + low milliseconds
    localparam int     SCALE_BITS = 16;
    localparam longint SCALE      = 64'sd1 <<< SCALE_BITS;
    localparam longint SPAN_MAX   = 64'sd2147483647;
    localparam longint SPAN_MIN   = -64'sd2147483647;

    // Legal span window in milliseconds
    localparam longint VMAX    = SPAN_MAX * SCALE + SCALE - 1;
    localparam longint VMIN    = (SPAN_MIN - 1) * SCALE + 1;
    localparam longint LIM_POS = VMAX;
    localparam longint LIM_NEG = -VMIN;

    // Operand value width and result value width
    localparam int VW  = 32 + SCALE_BITS;
    localparam int SPW = VW + 1;

    localparam int MS_PER_SEC  = 1000;
    localparam int SEC_PER_MIN = 60;
    localparam int MIN_PER_HR  = 60;
    localparam int HR_PER_DAY  = 24;

    typedef enum logic [3:0] {
        KIND_FROM_SEC = 4'd0,
        KIND_ADD      = 4'd1,
        KIND_SUB      = 4'd2,
        KIND_NEG      = 4'd3,
        KIND_MUL      = 4'd4,
        KIND_CMP      = 4'd5,
        KIND_TOT_MS   = 4'd6,
        KIND_TOT_SEC  = 4'd7,
        KIND_TOT_MIN  = 4'd8,
        KIND_TOT_HR   = 4'd9,
        KIND_PARTS    = 4'd10,
        KIND_ABS      = 4'd11
    } kind_t;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_ARG   = 2'd2;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    // Results settled before the divider chain
    typedef struct packed {
        kind_t       kind;
        logic [31:0] span_high;
        logic [15:0] span_low;
        logic [1:0]  order;
        logic [31:0] total;
        logic [1:0]  error;
        logic        neg;
    } front_t;

    // A truncated total of magnitude q fits in signed 32 bits
    function automatic logic tot_fit(input logic [37:0] q, input logic neg);
        tot_fit = (q <= 38'h07FFFFFFF) || (neg && (q == 38'h080000000));
    endfunction

endpackage

>>> rtl/tsa_cdiv.sv
`timescale 1ns / 1ps

// Unsigned divide by a constant, one DW-bit digit per two stages.
// Each digit: reciprocal multiply for the quotient digit, then the remainder.
module tsa_cdiv #(
    parameter int IW = 48,
    parameter int D  = 1000,
    parameter int DW = 16,
    parameter int SW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 vld_in,
    input  logic [IW-1:0]        num,
    input  logic [SW-1:0]        side_in,
    output logic                 vld_out,
    output logic [IW-1:0]        quo,
    output logic [$clog2(D)-1:0] rem,
    output logic [SW-1:0]        side_out
);

    localparam int ND  = (IW + DW - 1) / DW;
    localparam int PW  = ND * DW;
    localparam int RMW = $clog2(D);
    localparam int XW  = DW + RMW;
    localparam int SH  = XW + RMW;
    localparam int MW  = XW + 1;
    localparam int PRW = XW + MW;
    localparam logic [63:0]   MUL64 = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);
    localparam logic [MW-1:0] MUL   = MUL64[MW-1:0];
    localparam logic [XW-1:0] DX    = XW'(D);

    // Digits of num are replaced by quotient digits as they pass
    logic [PW-1:0]  num_s  [0:ND];
    logic [RMW-1:0] rem_s  [0:ND];
    logic [SW-1:0]  side_s [0:ND];
    logic           vld_s  [0:ND];

    assign num_s[0]  = PW'(num);
    assign rem_s[0]  = '0;
    assign side_s[0] = side_in;
    assign vld_s[0]  = vld_in;

    for (genvar k = 0; k < ND; k++)
    begin : g_dig
        logic [XW-1:0]  x;
        logic [PRW-1:0] prod;
        logic [XW-1:0]  x_reg;
        logic [DW-1:0]  qd_reg;
        logic [PW-1:0]  num_reg;
        logic [SW-1:0]  side_reg;
        logic           vld_reg;
        logic [XW-1:0]  rx;
        logic [PW-1:0]  num_ins;
        logic [RMW-1:0] rem2_reg;
        logic [PW-1:0]  num2_reg;
        logic [SW-1:0]  side2_reg;
        logic           vld2_reg;

        // quotient digit by reciprocal
        assign x    = {rem_s[k], num_s[k][PW-1-k*DW -: DW]};
        assign prod = PRW'(x) * PRW'(MUL);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg  <= 1'b0;
                vld2_reg <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg  <= vld_s[k];
                vld2_reg <= vld_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg    <= x;
                qd_reg   <= prod[SH +: DW];
                num_reg  <= num_s[k];
                side_reg <= side_s[k];
            end
        end

        // remainder and quotient digit insert
        always_comb
        begin
            rx      = x_reg - XW'(qd_reg) * DX;
            num_ins = num_reg;
            num_ins[PW-1-k*DW -: DW] = qd_reg;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem2_reg  <= rx[RMW-1:0];
                num2_reg  <= num_ins;
                side2_reg <= side_reg;
            end
        end

        assign num_s[k+1]  = num2_reg;
        assign rem_s[k+1]  = rem2_reg;
        assign side_s[k+1] = side2_reg;
        assign vld_s[k+1]  = vld2_reg;
    end

    assign quo      = num_s[ND][IW-1:0];
    assign rem      = rem_s[ND];
    assign side_out = side_s[ND];
    assign vld_out  = vld_s[ND];

endmodule

>>> rtl/time_span_alu_unit.sv
`timescale 1ns / 1ps

// Throughput: one word per cycle; the whole pipe advances together and
// holds while the response is stalled.
// Depth is set by the divide chain (by 1000, 60, 60, 24), two stages a digit.
// Reset clears the valid bits only; data registers are not reset.
module time_span_alu_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [3:0]         kind,
    input  logic signed [31:0] a_high,
    input  logic [15:0]        a_low,
    input  logic signed [31:0] b_high,
    input  logic [15:0]        b_low,
    input  logic signed [31:0] count_operand,
    input  logic [15:0]        extra_millis,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] span_high,
    output logic [15:0]        span_low,
    output logic [1:0]         order,
    output logic signed [31:0] total,
    output logic [20:0]        days,
    output logic [4:0]         hours,
    output logic [5:0]         minutes,
    output logic [5:0]         seconds,
    output logic [9:0]         millis,
    output logic               negative,
    output logic [1:0]         error
);

    localparam int VW  = tsa_pkg::VW;
    localparam int SPW = tsa_pkg::SPW;
    localparam int SB  = tsa_pkg::SCALE_BITS;
    localparam int FW  = $bits(tsa_pkg::front_t);
    localparam int SW2 = FW + 10 + 38;
    localparam int SW3 = SW2 + 6 + 32;
    localparam int SW4 = SW3 + 6 + 26;

    typedef struct packed {
        tsa_pkg::kind_t   kind;
        logic [SPW-1:0]   span;
        logic             lt;
        logic             eq;
        logic [VW-1:0]    mag_a;
        logic             mul_neg;
        logic             neg_a;
        logic             bad_ms;
        logic             fit32;
        logic [31:0]      lo32;
    } car_t;

    logic adv;

    assign req_stall = rsp_valid && rsp_stall;
    assign adv       = !req_stall;

    // Stage A: capture operands as millisecond values
    logic                 a_vld_reg;
    tsa_pkg::kind_t       a_kind_reg;
    logic signed [VW-1:0] a_va_reg;
    logic signed [VW-1:0] a_vb_reg;
    logic signed [31:0]   a_cnt_reg;
    logic [15:0]          a_ms_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_kind_reg <= tsa_pkg::kind_t'(kind);
            a_va_reg   <= {a_high, a_low};
            a_vb_reg   <= {b_high, b_low};
            a_cnt_reg  <= count_operand;
            a_ms_reg   <= extra_millis;
        end
    end

    // Stage B: add, subtract, negate, build, compare, magnitudes
    logic                  b_vld_reg;
    car_t                  b_car_reg;
    logic [31:0]           b_mag_c_reg;
    car_t                  b_car_next;
    logic signed [42:0]    fs;
    logic signed [SPW-1:0] va_x;
    logic signed [SPW-1:0] vb_x;
    logic [31:0]           mag_c;

    always_comb
    begin
        fs    = 43'(a_cnt_reg) * 43'(tsa_pkg::MS_PER_SEC) + 43'(a_ms_reg);
        va_x  = SPW'(a_va_reg);
        vb_x  = SPW'(a_vb_reg);
        mag_c = a_cnt_reg[31] ? 32'(-a_cnt_reg) : 32'(a_cnt_reg);

        b_car_next         = '0;
        b_car_next.kind    = a_kind_reg;
        b_car_next.mag_a   = a_va_reg[VW-1] ? VW'(-a_va_reg) : VW'(a_va_reg);
        b_car_next.lt      = a_va_reg < a_vb_reg;
        b_car_next.eq      = a_va_reg == a_vb_reg;
        b_car_next.neg_a   = a_va_reg[VW-1];
        b_car_next.mul_neg = a_va_reg[VW-1] ^ a_cnt_reg[31];
        b_car_next.bad_ms  = a_ms_reg >= 16'(tsa_pkg::MS_PER_SEC);
        b_car_next.fit32   = (&a_va_reg[VW-1:31]) || !(|a_va_reg[VW-1:31]);
        b_car_next.lo32    = a_va_reg[31:0];

        case (a_kind_reg)
            tsa_pkg::KIND_FROM_SEC: b_car_next.span = SPW'(fs);
            tsa_pkg::KIND_ADD:      b_car_next.span = va_x + vb_x;
            tsa_pkg::KIND_SUB:      b_car_next.span = va_x - vb_x;
            tsa_pkg::KIND_NEG:      b_car_next.span = -va_x;
            tsa_pkg::KIND_ABS:      b_car_next.span = SPW'(b_car_next.mag_a);
            default:                b_car_next.span = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_car_reg   <= b_car_next;
            b_mag_c_reg <= mag_c;
        end
    end

    // Stage C: partial products of the multiply
    logic        c_vld_reg;
    car_t        c_car_reg;
    logic [63:0] c_plo_reg;
    logic [47:0] c_phi_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_car_reg <= b_car_reg;
            c_plo_reg <= 64'(b_car_reg.mag_a[31:0]) * 64'(b_mag_c_reg);
            c_phi_reg <= 48'(b_car_reg.mag_a[VW-1:32]) * 48'(b_mag_c_reg);
        end
    end

    // Stage D: sum of partial products
    logic        d_vld_reg;
    car_t        d_car_reg;
    logic [79:0] d_prod_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_car_reg  <= c_car_reg;
            d_prod_reg <= 80'(c_plo_reg) + {c_phi_reg, 32'd0};
        end
    end

    // Stage E: multiply overflow and signed product
    logic     e_vld_reg;
    car_t     e_car_reg;
    logic     e_ovf_reg;
    car_t     e_car_next;
    logic     mul_ovf;

    always_comb
    begin
        mul_ovf = d_prod_reg > (d_car_reg.mul_neg ? 80'(tsa_pkg::LIM_NEG)
                                                  : 80'(tsa_pkg::LIM_POS));
        e_car_next = d_car_reg;
        if (d_car_reg.kind == tsa_pkg::KIND_MUL)
        begin
            e_car_next.span = d_car_reg.mul_neg ? -SPW'(d_prod_reg[VW-1:0])
                                                : SPW'(d_prod_reg[VW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_car_reg <= e_car_next;
            e_ovf_reg <= mul_ovf;
        end
    end

    // Span range check, normal form and error codes
    tsa_pkg::front_t       front;
    logic signed [SPW-1:0] e_span;
    logic                  in_rng;
    logic                  want_span;

    always_comb
    begin
        e_span    = $signed(e_car_reg.span);
        in_rng    = (e_span >= SPW'(tsa_pkg::VMIN)) && (e_span <= SPW'(tsa_pkg::VMAX));
        want_span = 1'b0;
        front      = '0;
        front.kind = e_car_reg.kind;
        front.neg  = e_car_reg.neg_a;

        case (e_car_reg.kind)
            tsa_pkg::KIND_FROM_SEC:
            begin
                if (e_car_reg.bad_ms)
                    front.error = tsa_pkg::ERR_ARG;
                else
                    want_span = 1'b1;
            end
            tsa_pkg::KIND_ADD, tsa_pkg::KIND_SUB, tsa_pkg::KIND_NEG, tsa_pkg::KIND_ABS:
                want_span = 1'b1;
            tsa_pkg::KIND_MUL:
            begin
                if (e_ovf_reg)
                    front.error = tsa_pkg::ERR_RANGE;
                else
                    want_span = 1'b1;
            end
            tsa_pkg::KIND_CMP:
                front.order = e_car_reg.lt ? tsa_pkg::ORD_LT :
                              (e_car_reg.eq ? tsa_pkg::ORD_EQ : tsa_pkg::ORD_GT);
            tsa_pkg::KIND_TOT_MS:
            begin
                if (e_car_reg.fit32)
                    front.total = e_car_reg.lo32;
                else
                    front.error = tsa_pkg::ERR_RANGE;
            end
            tsa_pkg::KIND_TOT_SEC, tsa_pkg::KIND_TOT_MIN, tsa_pkg::KIND_TOT_HR,
            tsa_pkg::KIND_PARTS:
                front.error = tsa_pkg::ERR_OK;
            default:
                front.error = tsa_pkg::ERR_ARG;
        endcase

        if (want_span)
        begin
            if (in_rng)
            begin
                front.span_high = e_span[SB +: 32];
                front.span_low  = e_span[SB-1:0];
            end
            else
            begin
                front.error = tsa_pkg::ERR_RANGE;
            end
        end
    end

    // Divide chain on the magnitude: ms, seconds, minutes, hours
    logic           d1_vld;
    logic [VW-1:0]  d1_quo;
    logic [9:0]     d1_rem;
    logic [FW-1:0]  d1_side;
    logic           d2_vld;
    logic [37:0]    d2_quo;
    logic [5:0]     d2_rem;
    logic [SW2-1:0] d2_side;
    logic           d3_vld;
    logic [31:0]    d3_quo;
    logic [5:0]     d3_rem;
    logic [SW3-1:0] d3_side;
    logic           d4_vld;
    logic [25:0]    d4_quo;
    logic [4:0]     d4_rem;
    logic [SW4-1:0] d4_side;

    tsa_cdiv #(.IW(VW), .D(tsa_pkg::MS_PER_SEC), .DW(16), .SW(FW)) u_div_ms (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (e_vld_reg),
        .num      (e_car_reg.mag_a),
        .side_in  (front),
        .vld_out  (d1_vld),
        .quo      (d1_quo),
        .rem      (d1_rem),
        .side_out (d1_side)
    );

    tsa_cdiv #(.IW(38), .D(tsa_pkg::SEC_PER_MIN), .DW(16), .SW(SW2)) u_div_sec (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (d1_vld),
        .num      (d1_quo[37:0]),
        .side_in  ({d1_side, d1_rem, d1_quo[37:0]}),
        .vld_out  (d2_vld),
        .quo      (d2_quo),
        .rem      (d2_rem),
        .side_out (d2_side)
    );

    tsa_cdiv #(.IW(32), .D(tsa_pkg::MIN_PER_HR), .DW(16), .SW(SW3)) u_div_min (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (d2_vld),
        .num      (d2_quo[31:0]),
        .side_in  ({d2_side, d2_rem, d2_quo[31:0]}),
        .vld_out  (d3_vld),
        .quo      (d3_quo),
        .rem      (d3_rem),
        .side_out (d3_side)
    );

    tsa_cdiv #(.IW(26), .D(tsa_pkg::HR_PER_DAY), .DW(16), .SW(SW4)) u_div_hr (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (d3_vld),
        .num      (d3_quo[25:0]),
        .side_in  ({d3_side, d3_rem, d3_quo[25:0]}),
        .vld_out  (d4_vld),
        .quo      (d4_quo),
        .rem      (d4_rem),
        .side_out (d4_side)
    );

    // Final assembly of the response word
    tsa_pkg::front_t f;
    logic [9:0]      f_ms;
    logic [37:0]     f_sec;
    logic [5:0]      f_secr;
    logic [31:0]     f_min;
    logic [5:0]      f_minr;
    logic [25:0]     f_hr;
    logic [37:0]     tq;
    logic [31:0]     total_next;
    logic [1:0]      error_next;
    logic [20:0]     days_next;
    logic [4:0]      hours_next;
    logic [5:0]      minutes_next;
    logic [5:0]      seconds_next;
    logic [9:0]      millis_next;
    logic            negative_next;

    always_comb
    begin
        {f, f_ms, f_sec, f_secr, f_min, f_minr, f_hr} = d4_side;
        total_next    = f.total;
        error_next    = f.error;
        days_next     = '0;
        hours_next    = '0;
        minutes_next  = '0;
        seconds_next  = '0;
        millis_next   = '0;
        negative_next = 1'b0;

        case (f.kind)
            tsa_pkg::KIND_TOT_SEC: tq = f_sec;
            tsa_pkg::KIND_TOT_MIN: tq = 38'(f_min);
            default:               tq = 38'(f_hr);
        endcase

        case (f.kind)
            tsa_pkg::KIND_TOT_SEC, tsa_pkg::KIND_TOT_MIN, tsa_pkg::KIND_TOT_HR:
            begin
                if (tsa_pkg::tot_fit(tq, f.neg))
                    total_next = f.neg ? -tq[31:0] : tq[31:0];
                else
                    error_next = tsa_pkg::ERR_RANGE;
            end
            tsa_pkg::KIND_PARTS:
            begin
                days_next     = d4_quo[20:0];
                hours_next    = d4_rem;
                minutes_next  = f_minr;
                seconds_next  = f_secr;
                millis_next   = f_ms;
                negative_next = f.neg;
            end
            default:
                negative_next = 1'b0;
        endcase
    end

    // Output register
    logic               rsp_valid_reg;
    logic signed [31:0] span_high_reg;
    logic [15:0]        span_low_reg;
    logic [1:0]         order_reg;
    logic signed [31:0] total_reg;
    logic [20:0]        days_reg;
    logic [4:0]         hours_reg;
    logic [5:0]         minutes_reg;
    logic [5:0]         seconds_reg;
    logic [9:0]         millis_reg;
    logic               negative_reg;
    logic [1:0]         error_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            span_high_reg <= f.span_high;
            span_low_reg  <= f.span_low;
            order_reg     <= f.order;
            total_reg     <= total_next;
            days_reg      <= days_next;
            hours_reg     <= hours_next;
            minutes_reg   <= minutes_next;
            seconds_reg   <= seconds_next;
            millis_reg    <= millis_next;
            negative_reg  <= negative_next;
            error_reg     <= error_next;
        end
    end

    // Valid bits of the front stages and the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            d_vld_reg     <= 1'b0;
            e_vld_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg     <= req_valid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            e_vld_reg     <= d_vld_reg;
            rsp_valid_reg <= d4_vld;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign span_high = span_high_reg;
    assign span_low  = span_low_reg;
    assign order     = order_reg;
    assign total     = total_reg;
    assign days      = days_reg;
    assign hours     = hours_reg;
    assign minutes   = minutes_reg;
    assign seconds   = seconds_reg;
    assign millis    = millis_reg;
    assign negative  = negative_reg;
    assign error     = error_reg;

endmodule

>>> tb/time_span_alu_unit_test.sv
`timescale 1ns / 1ps

module time_span_alu_unit_test;

    // Span window in milliseconds
    localparam longint SPAN_TOP = 64'sd2147483647 * 64'sd65536 + 64'sd65535;
    localparam longint SPAN_BOT = -64'sd2147483648 * 64'sd65536 + 64'sd1;
    localparam longint MS_MIN   = 64'sd60000;
    localparam longint MS_HOUR  = 64'sd3600000;
    localparam int     NUM_RAND = 1430;

    typedef struct {
        logic [3:0]         kind;
        logic signed [31:0] a_high;
        logic [15:0]        a_low;
        logic signed [31:0] b_high;
        logic [15:0]        b_low;
        logic signed [31:0] count_operand;
        logic [15:0]        extra_millis;
    } span_req_t;

    typedef struct {
        logic signed [31:0] span_high;
        logic [15:0]        span_low;
        logic [1:0]         order;
        logic signed [31:0] total;
        logic [20:0]        days;
        logic [4:0]         hours;
        logic [5:0]         minutes;
        logic [5:0]         seconds;
        logic [9:0]         millis;
        logic               negative;
        logic [1:0]         error;
    } span_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic [3:0] kind = '0;
    logic signed [31:0] a_high = '0;
    logic [15:0] a_low = '0;
    logic signed [31:0] b_high = '0;
    logic [15:0] b_low = '0;
    logic signed [31:0] count_operand = '0;
    logic [15:0] extra_millis = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic signed [31:0] span_high;
    logic [15:0] span_low;
    logic [1:0] order;
    logic signed [31:0] total;
    logic [20:0] days;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [9:0] millis;
    logic negative;
    logic [1:0] error;

    span_req_t pending_words[$];
    span_rsp_t expected_rsp[$];
    int fail_count = 0;
    int send_gap = 0;
    int recv_hold = 0;
    bit send_quiet = 1'b0;
    bit recv_quiet = 1'b0;

    time_span_alu_unit u_dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bit-exact model of the span unit
    function automatic span_rsp_t span_calc(span_req_t w);
        span_rsp_t r;
        longint va;
        longint vb;
        longint cnt;
        longint res;
        longint unsigned mv;
        longint unsigned mm;
        longint unsigned lim;
        longint unsigned mins;
        bit neg;
        bit is_span;
        bit is_total;
        r = '{default: '0};
        va = longint'(w.a_high) * 64'sd65536 + longint'(w.a_low);
        vb = longint'(w.b_high) * 64'sd65536 + longint'(w.b_low);
        cnt = longint'(w.count_operand);
        res = 0;
        is_span = 1'b0;
        is_total = 1'b0;
        case (w.kind)
            tsa_pkg::KIND_FROM_SEC:
            begin
                if (w.extra_millis >= 16'd1000)
                begin
                    r.error = tsa_pkg::ERR_ARG;
                    return r;
                end
                res = cnt * 1000 + longint'(w.extra_millis);
                is_span = 1'b1;
            end
            tsa_pkg::KIND_ADD: begin res = va + vb; is_span = 1'b1; end
            tsa_pkg::KIND_SUB: begin res = va - vb; is_span = 1'b1; end
            tsa_pkg::KIND_NEG: begin res = -va; is_span = 1'b1; end
            tsa_pkg::KIND_ABS: begin res = (va < 0) ? -va : va; is_span = 1'b1; end
            tsa_pkg::KIND_MUL:
            begin
                neg = (va < 0) != (cnt < 0);
                mv = (va < 0) ? -va : va;
                mm = (cnt < 0) ? -cnt : cnt;
                lim = neg ? -SPAN_BOT : SPAN_TOP;
                if (mm != 0 && mv > lim / mm)
                begin
                    r.error = tsa_pkg::ERR_RANGE;
                    return r;
                end
                res = neg ? -longint'(mv * mm) : longint'(mv * mm);
                is_span = 1'b1;
            end
            tsa_pkg::KIND_CMP:
            begin
                r.order = (va < vb) ? tsa_pkg::ORD_LT
                                    : ((va == vb) ? tsa_pkg::ORD_EQ : tsa_pkg::ORD_GT);
                return r;
            end
            tsa_pkg::KIND_TOT_MS:  begin res = va; is_total = 1'b1; end
            tsa_pkg::KIND_TOT_SEC: begin res = va / 1000; is_total = 1'b1; end
            tsa_pkg::KIND_TOT_MIN: begin res = va / MS_MIN; is_total = 1'b1; end
            tsa_pkg::KIND_TOT_HR:  begin res = va / MS_HOUR; is_total = 1'b1; end
            tsa_pkg::KIND_PARTS:
            begin
                mv = (va < 0) ? -va : va;
                mins = mv / 60000;
                r.days = 21'(mins / 1440);
                r.hours = 5'((mins / 60) % 24);
                r.minutes = 6'(mins % 60);
                r.seconds = 6'((mv / 1000) % 60);
                r.millis = 10'(mv % 1000);
                r.negative = va < 0;
                return r;
            end
            default:
            begin
                r.error = tsa_pkg::ERR_ARG;
                return r;
            end
        endcase
        if (is_span)
        begin
            if (res > SPAN_TOP || res < SPAN_BOT)
                r.error = tsa_pkg::ERR_RANGE;
            else
            begin
                // floor split: arithmetic shift and low bits
                r.span_high = res[47:16];
                r.span_low = res[15:0];
            end
        end
        else if (is_total)
        begin
            if (res > 64'sd2147483647 || res < -64'sd2147483648)
                r.error = tsa_pkg::ERR_RANGE;
            else
                r.total = res[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_high();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 200)) - 100);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return 32'h8000_0000 + $urandom_range(0, 3);
            4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    function automatic span_req_t pick_word();
        span_req_t w;
        w.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11));
        w.a_high = pick_high();
        w.b_high = ($urandom_range(0, 3) == 0) ? w.a_high : pick_high();
        w.a_low = 16'($urandom);
        w.b_low = ($urandom_range(0, 3) == 0) ? w.a_low : 16'($urandom);
        case ($urandom_range(0, 3))
            0: w.count_operand = $urandom;
            1: w.count_operand = 32'($signed($urandom_range(0, 20)) - 10);
            2: w.count_operand = 32'($signed($urandom_range(0, 200000)) - 100000);
            default: w.count_operand = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF
                                                                    : 32'h8000_0000;
        endcase
        w.extra_millis = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 999));
        return w;
    endfunction

    function automatic void add_word(logic [3:0] k, logic [31:0] ah, logic [15:0] al,
                                     logic [31:0] bh, logic [15:0] bl,
                                     logic [31:0] c, logic [15:0] em);
        pending_words.push_back('{k, ah, al, bh, bl, c, em});
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!(req_valid && req_stall))
        begin
            if (req_valid)
                expected_rsp.push_back(span_calc('{kind, a_high, a_low, b_high, b_low,
                                                   count_operand, extra_millis}));
            if (send_gap > 0)
            begin
                req_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_words.size() > 0)
            begin
                span_req_t w;
                w = pending_words.pop_front();
                kind <= w.kind;
                a_high <= w.a_high;
                a_low <= w.a_low;
                b_high <= w.b_high;
                b_low <= w.b_low;
                count_operand <= w.count_operand;
                extra_millis <= w.extra_millis;
                req_valid <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    send_quiet = ~send_quiet;
                send_gap <= send_quiet ? 0 : $urandom_range(0, 19);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            recv_hold <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                span_rsp_t e;
                int hold;
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual span %0h:%0h",
                             $time, span_high, span_low);
                    fail_count++;
                end
                else
                begin
                    e = expected_rsp.pop_front();
                    check_field("span_high", e.span_high, span_high);
                    check_field("span_low", e.span_low, span_low);
                    check_field("order", e.order, order);
                    check_field("total", e.total, total);
                    check_field("days", e.days, days);
                    check_field("hours", e.hours, hours);
                    check_field("minutes", e.minutes, minutes);
                    check_field("seconds", e.seconds, seconds);
                    check_field("millis", e.millis, millis);
                    check_field("negative", e.negative, negative);
                    check_field("error", e.error, error);
                end
                if ($urandom_range(0, 99) == 0)
                    recv_quiet = ~recv_quiet;
                // draw a hold length and stall before the next word
                hold = recv_quiet ? 0 : int'($urandom_range(0, 19));
                recv_hold <= (hold > 0) ? hold - 1 : 0;
                rsp_stall <= (hold > 0);
            end
            else if (recv_hold > 0)
            begin
                rsp_stall <= 1'b1;
                recv_hold <= recv_hold - 1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Stimulus and end of run
    initial
    begin
        // directed words: limits and error paths
        add_word(tsa_pkg::KIND_FROM_SEC, 0, 0, 0, 0, 32'h7FFF_FFFF, 16'd999);
        add_word(tsa_pkg::KIND_FROM_SEC, 0, 0, 0, 0, 32'h8000_0000, 16'd0);
        add_word(tsa_pkg::KIND_FROM_SEC, 0, 0, 0, 0, 32'd5, 16'd1000);
        add_word(tsa_pkg::KIND_FROM_SEC, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF);
        add_word(tsa_pkg::KIND_ADD, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF, 0, 0);
        add_word(tsa_pkg::KIND_ADD, 32'h7FFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 0, 0);
        add_word(tsa_pkg::KIND_SUB, 32'h8000_0001, 16'h0001, 32'h0, 16'h1, 0, 0);
        add_word(tsa_pkg::KIND_SUB, 32'h8000_0000, 16'h0, 32'h7FFF_FFFF, 16'hFFFF, 0, 0);
        add_word(tsa_pkg::KIND_NEG, 32'h8000_0000, 16'h0, 0, 0, 0, 0);
        add_word(tsa_pkg::KIND_NEG, 32'h8000_0000, 16'h1, 0, 0, 0, 0);
        add_word(tsa_pkg::KIND_ABS, 32'h8000_0000, 16'h0, 0, 0, 0, 0);
        add_word(tsa_pkg::KIND_ABS, 32'hFFFF_FFFF, 16'h8000, 0, 0, 0, 0);
        add_word(tsa_pkg::KIND_MUL, 32'h7FFF_FFFF, 16'hFFFF, 0, 0, 32'h0, 0);
        add_word(tsa_pkg::KIND_MUL, 32'h7FFF_FFFF, 16'hFFFF, 0, 0, 32'hFFFF_FFFF, 0);
        add_word(tsa_pkg::KIND_MUL, 32'h8000_0000, 16'h1, 0, 0, 32'hFFFF_FFFF, 0);
        add_word(tsa_pkg::KIND_MUL, 32'h1, 16'h0, 0, 0, 32'h8000_0000, 0);
        add_word(tsa_pkg::KIND_CMP, 32'h5, 16'h7, 32'h5, 16'h7, 0, 0);
        add_word(tsa_pkg::KIND_CMP, 32'h8000_0000, 16'h0, 32'h7FFF_FFFF, 16'hFFFF, 0, 0);
        add_word(tsa_pkg::KIND_CMP, 32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000, 16'h0, 0, 0);
        add_word(tsa_pkg::KIND_TOT_MS, 32'hFFFF_8000, 16'h0, 0, 0, 0, 0);
        add_word(tsa_pkg::KIND_TOT_MS, 32'h0000_8000, 16'h0, 0, 0, 0, 0);
        add_word(tsa_pkg::KIND_TOT_SEC, 32'h8000_0000, 16'h0, 0, 0, 0, 0);
        add_word(tsa_pkg::KIND_TOT_MIN, 32'h7FFF_FFFF, 16'hFFFF, 0, 0, 0, 0);
        add_word(tsa_pkg::KIND_TOT_HR, 32'h8000_0000, 16'h0, 0, 0, 0, 0);
        add_word(tsa_pkg::KIND_PARTS, 32'h8000_0000, 16'h0, 0, 0, 0, 0);
        add_word(tsa_pkg::KIND_PARTS, 32'h7FFF_FFFF, 16'hFFFF, 0, 0, 0, 0);
        for (int k = 12; k < 16; k++)
            add_word(4'(k), 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                     32'hFFFF_FFFF, 16'hFFFF);
        for (int n = 0; n < NUM_RAND; n++)
            pending_words.push_back(pick_word());

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> time_span_alu_unit.f
rtl/tsa_pkg.sv
rtl/tsa_cdiv.sv
rtl/time_span_alu_unit.sv
tb/time_span_alu_unit_test.sv
